/* hw/rtl/hfmt_pkg.sv */
// ----------------------------------------------------------------------------
// hfmt_pkg
// Shared types, constants and character helpers of the hex float formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package hfmt_pkg;

  // default bounds for the top level parameters
  localparam int MaxWidthDef     = 64;
  localparam int MaxPrecisionDef = 31;

  // binary64 layout
  localparam int FracBits    = 52;
  localparam int FracNibbles = 13;
  localparam int ExpBias     = 1023;
  localparam int SubnormExp  = 1022;

  // queue between front and back
  localparam int QueueDepth = 2;

  // ASCII codes
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChPoint = 8'h2e;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChLowP  = 8'h70;
  localparam logic [7:0] ChUpP   = 8'h50;
  localparam logic [7:0] CaseGap = 8'h20;

  // regions of the field in print order; also the back end sequencer state
  typedef enum logic [3:0] {
    R_LPAD,
    R_SIGN,
    R_PFX0,
    R_PFXX,
    R_ZPAD,
    R_LEAD,
    R_POINT,
    R_FRAC,
    R_PCHR,
    R_ESGN,
    R_EDIG,
    R_WORD,
    R_RPAD
  } hfmt_region_t;

  localparam int NumRegions = 13;

  // one classified item, as handed from front to back
  typedef struct packed {
    logic [7:0]                sign_ch;
    logic                      is_nan;
    logic                      upper;
    logic                      lead;
    logic [FracBits-1:0]       frac;
    logic [4:0]                ndig;
    logic                      eneg;
    logic [3:0][3:0]           edig;
    logic [2:0]                endig;
    logic [5:0]                pad;
    logic [NumRegions-1:0]     on;
  } hfmt_desc_t;

  // hex digit to ASCII
  function automatic logic [7:0] hex_char(input logic [3:0] d, input logic up);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = ChZero + 8'(d);
    end else begin
      c = (up ? ChUpA : ChLowA) + 8'(d) - 8'd10;
    end
    return c;
  endfunction

  // letters of inf / nan
  function automatic logic [7:0] word_char(input logic nan, input logic up,
                                           input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = nan ? 8'h6e : 8'h69;
      2'd1:    c = nan ? 8'h61 : 8'h6e;
      default: c = nan ? 8'h6e : 8'h66;
    endcase
    return up ? c - CaseGap : c;
  endfunction

  // first enabled region at or above a start position
  function automatic hfmt_region_t first_region(input logic [NumRegions-1:0] on,
                                                input logic [3:0] from);
    hfmt_region_t r;
    logic         found;
    r     = R_RPAD;
    found = 1'b0;
    for (int i = 0; i < NumRegions; i++) begin
      if (!found && on[i] && (4'(i) >= from)) begin
        r     = hfmt_region_t'(4'(i));
        found = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/hfmt_front.sv */
// ----------------------------------------------------------------------------
// hfmt_front
// Three stage front end: classify and round, split the exponent into decimal
// digits, then lay out the field regions and push one word to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hfmt_front #(
  parameter int MAX_WIDTH     = hfmt_pkg::MaxWidthDef,
  parameter int MAX_PRECISION = hfmt_pkg::MaxPrecisionDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [63:0]        value_bits,
  input  logic [4:0]         precision,
  input  logic               shortest,
  input  logic               alternate,
  input  logic               upper,
  input  logic [6:0]         width,
  input  logic               left_align,
  input  logic               zero_pad,
  input  logic               plus_sign,
  input  logic               space_sign,
  input  logic               q_full,
  output logic               q_push,
  output hfmt_pkg::hfmt_desc_t q_data
);

  localparam logic [5:0] MaxPrec = 6'(MAX_PRECISION);
  localparam logic [6:0] MaxWid  = 7'(MAX_WIDTH);

  // fields carried from the rounding stage onwards
  typedef struct packed {
    logic                          has_sign;
    logic [7:0]                    sign_ch;
    logic                          special;
    logic                          is_nan;
    logic                          upper;
    logic                          alt;
    logic                          left;
    logic                          zero;
    logic                          lead;
    logic [hfmt_pkg::FracBits-1:0] frac;
    logic [4:0]                    ndig;
    logic                          eneg;
    logic [6:0]                    width;
  } hfmt_item_t;

  // stage a: captured request
  logic        a_valid;
  logic [63:0] a_bits;
  logic [4:0]  a_prec;
  logic        a_shortest;
  logic        a_alt;
  logic        a_upper;
  logic [6:0]  a_width;
  logic        a_left;
  logic        a_zero;
  logic        a_plus;
  logic        a_space;

  // stage b and c registers
  logic       b_valid;
  hfmt_item_t b_item;
  logic [10:0] b_eabs;
  logic       c_valid;
  hfmt_item_t c_item;
  logic       c_th;
  logic [3:0] c_hund;
  logic [6:0] c_rem2;

  logic a_ready, b_ready, c_ready;

  // stage a combinational results
  hfmt_item_t  a_item;
  logic [10:0] a_eabs;
  logic [10:0] ef;
  logic        mag_zero;
  logic [52:0] sig;
  logic [5:0]  digits_p;
  logic [4:0]  digits_s;
  logic        do_round;
  logic [5:0]  sh;
  logic [52:0] lowmask;
  logic        guard, sticky, lsb, inc;
  logic [53:0] rounded;
  logic        carry;
  logic [52:0] sig_r;
  logic signed [11:0] ex0, ex_val;

  // stage b combinational results
  logic        b_th;
  logic [9:0]  b_rem;
  logic [15:0] b_hprod;
  logic [3:0]  b_hund;
  logic [6:0]  b_rem2;

  // stage c combinational results
  logic [15:0] c_tprod;
  logic [3:0]  c_tens, c_ones;
  logic [2:0]  c_endig;
  logic [3:0][3:0] c_edig;
  logic        c_point;
  logic [6:0]  c_len;
  logic [5:0]  c_pad;
  logic        c_padded;

  // stage handshake
  assign c_ready = !c_valid || !q_full;
  assign b_ready = !b_valid || c_ready;
  assign a_ready = !a_valid || b_ready;
  assign busy    = !a_ready;
  assign q_push  = c_valid && !q_full;

  // classify, round and work out the binary exponent
  always_comb begin
    ef       = a_bits[62:52];
    mag_zero = (a_bits[62:0] == 63'd0);
    sig      = {|ef, a_bits[51:0]};

    digits_p = ({1'b0, a_prec} > MaxPrec) ? MaxPrec : {1'b0, a_prec};

    digits_s = 5'd0;
    for (int i = 0; i < hfmt_pkg::FracNibbles; i++) begin
      if (a_bits[hfmt_pkg::FracBits-1-4*i -: 4] != 4'd0) begin
        digits_s = 5'(i + 1);
      end
    end

    do_round = !a_shortest && (digits_p < 6'(hfmt_pkg::FracNibbles));
    sh       = do_round ? 6'(hfmt_pkg::FracBits) - {digits_p[3:0], 2'b00} : 6'd4;
    lowmask  = (53'd1 << sh) - 53'd1;
    guard    = sig[sh - 6'd1];
    sticky   = |(sig & (lowmask >> 1));
    lsb      = sig[sh];
    inc      = guard && (sticky || lsb);
    rounded  = do_round ? ({1'b0, sig & ~lowmask} + (54'(inc) << sh)) : {1'b0, sig};
    carry    = rounded[53];
    sig_r    = carry ? rounded[53:1] : rounded[52:0];

    if (mag_zero) begin
      ex0 = 12'sd0;
    end else if (ef == 11'd0) begin
      ex0 = -12'(hfmt_pkg::SubnormExp);
    end else begin
      ex0 = $signed({1'b0, ef}) - 12'(hfmt_pkg::ExpBias);
    end
    ex_val = ex0 + $signed(12'(carry));
    a_eabs = ex_val[11] ? 11'(-ex_val) : 11'(ex_val);

    a_item.has_sign = a_bits[63] || a_plus || a_space;
    a_item.sign_ch  = a_bits[63] ? hfmt_pkg::ChMinus :
                      (a_plus ? hfmt_pkg::ChPlus : hfmt_pkg::ChSpace);
    a_item.special  = &ef;
    a_item.is_nan   = (&ef) && (|a_bits[51:0]);
    a_item.upper    = a_upper;
    a_item.alt      = a_alt;
    a_item.left     = a_left;
    a_item.zero     = a_zero && !(&ef) && !a_left;
    a_item.lead     = sig_r[52];
    a_item.frac     = sig_r[51:0];
    a_item.ndig     = a_shortest ? digits_s : digits_p[4:0];
    a_item.eneg     = ex_val[11];
    a_item.width    = (a_width > MaxWid) ? MaxWid : a_width;
  end

  // thousands and hundreds of the exponent
  always_comb begin
    b_th    = (b_eabs >= 11'd1000);
    b_rem   = 10'(b_eabs - (b_th ? 11'd1000 : 11'd0));
    b_hprod = 16'(b_rem) * 16'd41;
    b_hund  = b_hprod[15:12];
    b_rem2  = 7'(b_rem - 10'(b_hund) * 10'd100);
  end

  // tens and ones, field length, padding and region layout
  always_comb begin
    c_tprod = 16'(c_rem2) * 16'd205;
    c_tens  = c_tprod[14:11];
    c_ones  = 4'(c_rem2 - 7'(c_tens) * 7'd10);

    priority if (c_th) begin
      c_endig = 3'd4;
      c_edig  = {c_ones, c_tens, c_hund, 4'd1};
    end else if (c_hund != 4'd0) begin
      c_endig = 3'd3;
      c_edig  = {4'd0, c_ones, c_tens, c_hund};
    end else if (c_tens != 4'd0) begin
      c_endig = 3'd2;
      c_edig  = {4'd0, 4'd0, c_ones, c_tens};
    end else begin
      c_endig = 3'd1;
      c_edig  = {4'd0, 4'd0, 4'd0, c_ones};
    end

    c_point  = (c_item.ndig != 5'd0) || c_item.alt;
    c_len    = 7'(c_item.has_sign) +
               (c_item.special ? 7'd3 :
                7'd5 + 7'(c_point) + 7'(c_item.ndig) + 7'(c_endig));
    c_pad    = (c_item.width > c_len) ? 6'(c_item.width - c_len) : 6'd0;
    c_padded = (c_pad != 6'd0);

    q_data.sign_ch = c_item.sign_ch;
    q_data.is_nan  = c_item.is_nan;
    q_data.upper   = c_item.upper;
    q_data.lead    = c_item.lead;
    q_data.frac    = c_item.frac;
    q_data.ndig    = c_item.ndig;
    q_data.eneg    = c_item.eneg;
    q_data.edig    = c_edig;
    q_data.endig   = c_endig;
    q_data.pad     = c_pad;

    q_data.on          = '0;
    q_data.on[hfmt_pkg::R_LPAD]  = !c_item.left && !c_item.zero && c_padded;
    q_data.on[hfmt_pkg::R_SIGN]  = c_item.has_sign;
    q_data.on[hfmt_pkg::R_PFX0]  = !c_item.special;
    q_data.on[hfmt_pkg::R_PFXX]  = !c_item.special;
    q_data.on[hfmt_pkg::R_ZPAD]  = c_item.zero && c_padded;
    q_data.on[hfmt_pkg::R_LEAD]  = !c_item.special;
    q_data.on[hfmt_pkg::R_POINT] = !c_item.special && c_point;
    q_data.on[hfmt_pkg::R_FRAC]  = !c_item.special && (c_item.ndig != 5'd0);
    q_data.on[hfmt_pkg::R_PCHR]  = !c_item.special;
    q_data.on[hfmt_pkg::R_ESGN]  = !c_item.special;
    q_data.on[hfmt_pkg::R_EDIG]  = !c_item.special;
    q_data.on[hfmt_pkg::R_WORD]  = c_item.special;
    q_data.on[hfmt_pkg::R_RPAD]  = c_item.left && c_padded;
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= start;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) c_valid <= b_valid;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (start && a_ready) begin
      a_bits     <= value_bits;
      a_prec     <= precision;
      a_shortest <= shortest;
      a_alt      <= alternate;
      a_upper    <= upper;
      a_width    <= width;
      a_left     <= left_align;
      a_zero     <= zero_pad;
      a_plus     <= plus_sign;
      a_space    <= space_sign;
    end
    if (a_valid && b_ready) begin
      b_item <= a_item;
      b_eabs <= a_eabs;
    end
    if (b_valid && c_ready) begin
      c_item <= b_item;
      c_th   <= b_th;
      c_hund <= b_hund;
      c_rem2 <= b_rem2;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hfmt_queue.sv */
// ----------------------------------------------------------------------------
// hfmt_queue
// Short register queue of classified words between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hfmt_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  hfmt_pkg::hfmt_desc_t wdata,
  output logic                 full,
  input  logic                 pop,
  output hfmt_pkg::hfmt_desc_t rdata,
  output logic                 empty
);

  localparam int Depth = hfmt_pkg::QueueDepth;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  hfmt_pkg::hfmt_desc_t entries [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full  = (count == CntW'(Depth));
  assign empty = (count == '0);
  assign rdata = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + CntW'(push) - CntW'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wdata;
  end

endmodule

`default_nettype wire

/* hw/rtl/hfmt_back.sv */
// ----------------------------------------------------------------------------
// hfmt_back
// Character sequencer: walks the enabled regions of one word and puts out
// one character per cycle, loading the next queued word on the last character.
// ----------------------------------------------------------------------------
`default_nettype none

module hfmt_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  hfmt_pkg::hfmt_desc_t q_data,
  output logic [7:0]           out_char,
  output logic                 last,
  output logic                 strobe
);

  logic                   active, active_next;
  hfmt_pkg::hfmt_desc_t   cur;
  hfmt_pkg::hfmt_region_t region, region_next;
  logic [5:0]             cnt, cnt_next;

  logic [5:0]  rlen_m1;
  logic        done;
  logic        at_end;
  logic        finish;
  logic [7:0]  ch;
  logic [3:0]  nibs [hfmt_pkg::FracNibbles];
  logic [3:0]  nib;
  logic [hfmt_pkg::NumRegions-1:0] above;

  // length of the current region and end of word detection
  always_comb begin
    unique case (region)
      hfmt_pkg::R_LPAD, hfmt_pkg::R_ZPAD, hfmt_pkg::R_RPAD: rlen_m1 = cur.pad - 6'd1;
      hfmt_pkg::R_FRAC: rlen_m1 = 6'(cur.ndig) - 6'd1;
      hfmt_pkg::R_EDIG: rlen_m1 = 6'(cur.endig) - 6'd1;
      hfmt_pkg::R_WORD: rlen_m1 = 6'd2;
      default:          rlen_m1 = 6'd0;
    endcase
    done   = (cnt == rlen_m1);
    above  = cur.on & ~((hfmt_pkg::NumRegions'(2) << region) -
                        hfmt_pkg::NumRegions'(1));
    at_end = (above == '0);
    finish = active && done && at_end;
    q_pop  = !q_empty && (!active || finish);
  end

  // next state
  always_comb begin
    region_next = region;
    cnt_next    = cnt;
    active_next = active;
    priority if (q_pop) begin
      region_next = hfmt_pkg::first_region(q_data.on, 4'd0);
      cnt_next    = 6'd0;
      active_next = 1'b1;
    end else if (finish) begin
      active_next = 1'b0;
    end else if (active) begin
      if (done) begin
        region_next = hfmt_pkg::first_region(cur.on, 4'(region) + 4'd1);
        cnt_next    = 6'd0;
      end else begin
        cnt_next = cnt + 6'd1;
      end
    end
  end

  // character of the current position
  always_comb begin
    for (int i = 0; i < hfmt_pkg::FracNibbles; i++) begin
      nibs[i] = cur.frac[hfmt_pkg::FracBits-1-4*i -: 4];
    end
    nib = (cnt < 6'(hfmt_pkg::FracNibbles)) ? nibs[cnt[3:0]] : 4'd0;

    unique case (region)
      hfmt_pkg::R_LPAD:  ch = hfmt_pkg::ChSpace;
      hfmt_pkg::R_SIGN:  ch = cur.sign_ch;
      hfmt_pkg::R_PFX0:  ch = hfmt_pkg::ChZero;
      hfmt_pkg::R_PFXX:  ch = cur.upper ? hfmt_pkg::ChUpX : hfmt_pkg::ChLowX;
      hfmt_pkg::R_ZPAD:  ch = hfmt_pkg::ChZero;
      hfmt_pkg::R_LEAD:  ch = hfmt_pkg::ChZero + 8'(cur.lead);
      hfmt_pkg::R_POINT: ch = hfmt_pkg::ChPoint;
      hfmt_pkg::R_FRAC:  ch = hfmt_pkg::hex_char(nib, cur.upper);
      hfmt_pkg::R_PCHR:  ch = cur.upper ? hfmt_pkg::ChUpP : hfmt_pkg::ChLowP;
      hfmt_pkg::R_ESGN:  ch = cur.eneg ? hfmt_pkg::ChMinus : hfmt_pkg::ChPlus;
      hfmt_pkg::R_EDIG:  ch = hfmt_pkg::ChZero + 8'(cur.edig[cnt[1:0]]);
      hfmt_pkg::R_WORD:  ch = hfmt_pkg::word_char(cur.is_nan, cur.upper, cnt[1:0]);
      hfmt_pkg::R_RPAD:  ch = hfmt_pkg::ChSpace;
      default:           ch = hfmt_pkg::ChSpace;
    endcase
  end

  // sequencer state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      region <= hfmt_pkg::R_LPAD;
      cnt    <= 6'd0;
      strobe <= 1'b0;
      last   <= 1'b0;
    end else begin
      active <= active_next;
      region <= region_next;
      cnt    <= cnt_next;
      strobe <= active;
      last   <= finish;
    end
  end

  // word and character payload
  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
    out_char <= ch;
  end

endmodule

`default_nettype wire

/* hw/rtl/hex_float_text_formatter.sv */
// ----------------------------------------------------------------------------
// hex_float_text_formatter
// Formats a binary64 bit pattern as %a / %A text, one character per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low; the
//   value bits and conversion options sit on their own ports in that cycle.
//   The formatted field comes out one character per cycle on out_char with
//   strobe high for exactly one cycle each; last marks the final character.
//   The receiver cannot hold characters off.
// A taken request passes the stage a, b and c registers, the queue and
//   the sequencer word register into the character output register, when the
//   character sequencer is free. Each field is 3 to 64 characters, set out by
//   the single character output register. The next field follows its
//   predecessor directly when its word is already in the queue.
// Requests flow through a three stage front end (round, exponent digits,
//   layout) and a two word queue; busy rises only while all of that is full,
//   so up to five requests may wait behind the field being printed.
// Reset (rst, synchronous) empties the pipeline and queue and drops strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_float_text_formatter #(
  parameter int MAX_WIDTH     = hfmt_pkg::MaxWidthDef,
  parameter int MAX_PRECISION = hfmt_pkg::MaxPrecisionDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] value_bits,
  input  logic [4:0]  precision,
  input  logic        shortest,
  input  logic        alternate,
  input  logic        upper,
  input  logic [6:0]  width,
  input  logic        left_align,
  input  logic        zero_pad,
  input  logic        plus_sign,
  input  logic        space_sign,
  output logic [7:0]  out_char,
  output logic        last,
  output logic        strobe
);

  hfmt_pkg::hfmt_desc_t push_word, pop_word;
  logic q_push, q_full, q_pop, q_empty;

  // classify and lay out each request
  hfmt_front #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_PRECISION (MAX_PRECISION)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value_bits (value_bits),
    .precision  (precision),
    .shortest   (shortest),
    .alternate  (alternate),
    .upper      (upper),
    .width      (width),
    .left_align (left_align),
    .zero_pad   (zero_pad),
    .plus_sign  (plus_sign),
    .space_sign (space_sign),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (push_word)
  );

  // decoupling queue
  hfmt_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (push_word),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (pop_word),
    .empty (q_empty)
  );

  // character sequencer
  hfmt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_data   (pop_word),
    .out_char (out_char),
    .last     (last),
    .strobe   (strobe)
  );

endmodule

`default_nettype wire

/* hw/rtl/hfmt_checker.sv */
// ----------------------------------------------------------------------------
// hfmt_checker
// Port level checks of the formatter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hfmt_checker (
  input wire       clk,
  input wire       rst,
  input wire       busy,
  input wire [7:0] out_char,
  input wire       last,
  input wire       strobe
);

  // reset leaves no character in flight
  a_reset_quiet: assert property (@(posedge clk) rst |=> !strobe && !last)
    else $error("character shown right after reset");

  // reset leaves the front end free
  a_reset_free: assert property (@(posedge clk) rst |=> !busy)
    else $error("busy right after reset");

  // the end of field mark only rides on a character
  a_last_strobe: assert property (@(posedge clk) disable iff (rst) last |-> strobe)
    else $error("last without strobe");

  // every character of a field is printable
  a_printable: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (out_char >= 8'h20 && out_char <= 8'h7e))
    else $error("non printable character");

  // strobe does not rise straight out of reset
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(strobe) |-> !$past(rst))
    else $error("character started straight out of reset");

endmodule

bind hex_float_text_formatter hfmt_checker u_hfmt_checker (
  .clk      (clk),
  .rst      (rst),
  .busy     (busy),
  .out_char (out_char),
  .last     (last),
  .strobe   (strobe)
);

`default_nettype wire
